// ----- rtl/rss_pkg.sv -----
// shared constants, types and sequencer states for the running sample statistics block
package rss_pkg;

    // default sizing of the accumulators
    localparam int COUNT_BITS_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 24;

    // fixed widths of the word fields
    localparam int COUNT_W     = 16;
    localparam int SAMPLE_W    = 24;
    localparam int VAR_W       = 48;
    localparam int DEV_W       = 24;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_FIELD_W = COUNT_W + 4 * SAMPLE_W + VAR_W + 1;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    // report sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVM,
        S_MULA,
        S_MULB,
        S_DIVV,
        S_SQRT,
        S_DONE
    } t_rss_state;

    // handshake between the accumulator side and the report engine
    typedef struct packed {
        logic start;
        logic take;
    } t_rss_ctl;

endpackage

// ----- rtl/rss_engine.sv -----
// report engine: mean, variance and deviation on one shared add/subtract unit
module rss_engine #(
    parameter int COUNT_BITS  = rss_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = rss_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  rss_pkg::t_rss_ctl                          i_ctl,
    input  logic [COUNT_BITS-1:0]                      i_count,
    input  logic signed [SAMPLE_BITS+COUNT_BITS-1:0]   i_sum,
    input  logic [2*SAMPLE_BITS+COUNT_BITS-1:0]        i_sqsum,
    output logic                                       o_done,
    output logic signed [SAMPLE_BITS-1:0]              o_mean,
    output logic [2*SAMPLE_BITS-1:0]                   o_var,
    output logic [SAMPLE_BITS-1:0]                     o_dev
);

    localparam int CB = COUNT_BITS;
    localparam int SB = SAMPLE_BITS;
    localparam int SW = SB + CB;
    localparam int QW = 2 * SB + CB;
    localparam int DW = 2 * SB + 2 * CB;
    localparam int AW = DW + 1;
    localparam int VW = 2 * SB;
    localparam int NW = 2 * CB;
    localparam int RW = SB + 2;
    localparam int CW = $clog2(DW);

    localparam logic [CW-1:0] DIV_LAST  = CW'(DW - 1);
    localparam logic [CW-1:0] MULA_LAST = CW'(CB - 1);
    localparam logic [CW-1:0] MULB_LAST = CW'(SW - 1);
    localparam logic [CW-1:0] SQRT_LAST = CW'(SB - 1);

    rss_pkg::t_rss_state r_state, n_state;
    logic [CW-1:0]       r_cnt;

    logic [CB-1:0]        r_n;
    logic [NW-1:0]        r_nsq;
    logic                 r_neg;
    logic [SW-1:0]        r_mag;
    logic [QW-1:0]        r_sq;
    logic [DW-1:0]        r_acc;
    logic [DW-1:0]        r_mcand;
    logic [SW-1:0]        r_mplier;
    logic [NW-1:0]        r_rem;
    logic signed [SB-1:0] r_mean;
    logic [VW-1:0]        r_var;
    logic [VW-1:0]        r_sqv;
    logic [RW-1:0]        r_srem;
    logic [SB-1:0]        r_root;

    logic [SW-1:0] st_mag;
    logic [NW-1:0] st_nsq;
    logic          cnt_last;

    logic [AW-1:0] alu_a, alu_b, alu_res;
    logic          alu_sub, alu_neg;

    logic [NW:0]    d_trial;
    logic [NW-1:0]  d_div;
    logic           q_bit;
    logic [NW-1:0]  d_rem_nxt;
    logic [DW-1:0]  q_new;
    logic [SB-1:0]  q_mag;

    logic [RW+1:0]  s_ta;
    logic [SB+1:0]  s_tb;
    logic [RW-1:0]  s_rem_nxt;
    logic [SB-1:0]  s_root_nxt;

    assign st_mag   = i_sum[SW-1] ? $unsigned(-i_sum) : $unsigned(i_sum);
    assign st_nsq   = NW'(i_count) * NW'(i_count);
    assign cnt_last = (r_cnt == '0);

    // restoring divide step
    assign d_trial   = {r_rem, r_acc[DW-1]};
    assign d_div     = (r_state == rss_pkg::S_DIVM) ? NW'(r_n) : r_nsq;
    assign q_bit     = ~alu_neg;
    assign d_rem_nxt = q_bit ? alu_res[NW-1:0] : d_trial[NW-1:0];
    assign q_new     = {r_acc[DW-2:0], q_bit};
    assign q_mag     = q_new[SB-1:0];

    // digit-by-digit square root step
    assign s_ta       = {r_srem, r_sqv[VW-1 -: 2]};
    assign s_tb       = {r_root, 2'b01};
    assign s_rem_nxt  = alu_neg ? s_ta[RW-1:0] : alu_res[RW-1:0];
    assign s_root_nxt = {r_root[SB-2:0], ~alu_neg};

    // the shared unit
    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_neg = alu_res[AW-1];

    always_comb begin
        n_state = r_state;
        case (r_state)
            rss_pkg::S_IDLE: if (i_ctl.start) n_state = rss_pkg::S_DIVM;
            rss_pkg::S_DIVM: if (cnt_last) n_state = rss_pkg::S_MULA;
            rss_pkg::S_MULA: if (cnt_last) n_state = rss_pkg::S_MULB;
            rss_pkg::S_MULB: if (cnt_last) n_state = rss_pkg::S_DIVV;
            rss_pkg::S_DIVV: if (cnt_last) n_state = rss_pkg::S_SQRT;
            rss_pkg::S_SQRT: if (cnt_last) n_state = rss_pkg::S_DONE;
            rss_pkg::S_DONE: if (i_ctl.take) n_state = rss_pkg::S_IDLE;
            default:         n_state = rss_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        o_done  = 1'b0;
        case (r_state)
            rss_pkg::S_DIVM, rss_pkg::S_DIVV: begin
                alu_a   = AW'(d_trial);
                alu_b   = AW'(d_div);
                alu_sub = 1'b1;
            end
            rss_pkg::S_MULA: begin
                alu_a = AW'(r_acc);
                alu_b = AW'(r_mcand);
            end
            rss_pkg::S_MULB: begin
                alu_a   = AW'(r_acc);
                alu_b   = AW'(r_mcand);
                alu_sub = 1'b1;
            end
            rss_pkg::S_SQRT: begin
                alu_a   = AW'(s_ta);
                alu_b   = AW'(s_tb);
                alu_sub = 1'b1;
            end
            rss_pkg::S_DONE: o_done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rss_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                rss_pkg::S_IDLE: r_cnt <= DIV_LAST;
                rss_pkg::S_DIVM: r_cnt <= cnt_last ? MULA_LAST : r_cnt - 1'b1;
                rss_pkg::S_MULA: r_cnt <= cnt_last ? MULB_LAST : r_cnt - 1'b1;
                rss_pkg::S_MULB: r_cnt <= cnt_last ? DIV_LAST  : r_cnt - 1'b1;
                rss_pkg::S_DIVV: r_cnt <= cnt_last ? SQRT_LAST : r_cnt - 1'b1;
                rss_pkg::S_SQRT: r_cnt <= cnt_last ? r_cnt     : r_cnt - 1'b1;
                default:         r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rss_pkg::S_IDLE: begin
                if (i_ctl.start) begin
                    r_n   <= i_count;
                    r_nsq <= st_nsq;
                    r_neg <= i_sum[SW-1];
                    r_mag <= st_mag;
                    r_sq  <= i_sqsum;
                    r_acc <= DW'(st_mag);
                    r_rem <= '0;
                end
            end
            rss_pkg::S_DIVM: begin
                r_rem <= d_rem_nxt;
                if (cnt_last) begin
                    r_mean   <= r_neg ? $signed(-q_mag) : $signed(q_mag);
                    r_acc    <= '0;
                    r_mcand  <= DW'(r_sq);
                    r_mplier <= SW'(r_n);
                end else begin
                    r_acc <= q_new;
                end
            end
            rss_pkg::S_MULA: begin
                if (r_mplier[0]) r_acc <= alu_res[DW-1:0];
                if (cnt_last) begin
                    r_mcand  <= DW'(r_mag);
                    r_mplier <= r_mag;
                end else begin
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                end
            end
            rss_pkg::S_MULB: begin
                // partial sums stay above the final n*S2 - S1*S1, never negative
                if (r_mplier[0]) r_acc <= alu_res[DW-1:0];
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_rem    <= '0;
            end
            rss_pkg::S_DIVV: begin
                r_rem <= d_rem_nxt;
                r_acc <= q_new;
                if (cnt_last) begin
                    r_var  <= q_new[VW-1:0];
                    r_sqv  <= q_new[VW-1:0];
                    r_srem <= '0;
                    r_root <= '0;
                end
            end
            rss_pkg::S_SQRT: begin
                r_sqv  <= r_sqv << 2;
                r_srem <= s_rem_nxt;
                r_root <= s_root_nxt;
            end
            default: ;
        endcase
    end

    assign o_mean = r_mean;
    assign o_var  = r_var;
    assign o_dev  = r_root;

endmodule

// ----- rtl/running_sample_statistics.sv -----
// top level: sample accumulators, report engine hookup and result word register
//
//  channel  | dir | tdata                          | tuser    | tlast
//  ---------+-----+--------------------------------+----------+-------
//  s (in)   | in  | sample                         | restart  | report
//  m (out)  | out | count, mean, var, dev, min,    | -        | -
//           |     | max, overflowed                |          |
//
// a plain sample word is taken every cycle while tready is high: square in the first
// stage, fold into the sums in the second
// a report word drops tready until its result is in the output register, and no
// further word is taken until then; the engine runs a mean divide, a multiply
// forming n*S2, a multiply subtracting S1*S1, a variance divide and a square
// root on the shared add/subtract unit, each divide one quotient bit per cycle
// synchronous active-low reset clears the set: count, sums, min, max, overflow flag
// a stalled result word holds in the output register while plain samples keep flowing
module running_sample_statistics #(
    parameter int COUNT_BITS  = rss_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = rss_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [rss_pkg::IN_DATA_W-1:0]    i_s_tdata,   // [23:0] sample
    input  logic                             i_s_tuser,   // [0] restart
    input  logic                             i_s_tlast,   // report
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [15:0] sample_count, [39:16] mean_value, [87:40] variance_value,
    // [111:88] deviation_value, [135:112] smallest, [159:136] largest,
    // [160] overflowed, rest zero
    output logic [rss_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    localparam int CB    = COUNT_BITS;
    localparam int SB    = SAMPLE_BITS;
    localparam int SW    = SB + CB;
    localparam int QW    = 2 * SB + CB;
    localparam int CNT_W = rss_pkg::COUNT_W;
    localparam int SMP_W = rss_pkg::SAMPLE_W;
    localparam int VAR_W = rss_pkg::VAR_W;
    localparam int DEV_W = rss_pkg::DEV_W;

    localparam logic [CB-1:0]        CNT_MAX  = {CB{1'b1}};
    localparam logic signed [SB-1:0] MOST_POS = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] MOST_NEG = {1'b1, {(SB-1){1'b0}}};

    // accept and square stage
    logic                   in_accept;
    logic signed [SB-1:0]   in_samp;
    logic signed [2*SB-1:0] in_sq;

    logic                   r_p_vld;
    logic signed [SB-1:0]   r_p_samp;
    logic [2*SB-1:0]        r_p_sq;
    logic                   r_p_rst;
    logic                   r_p_rep;

    // running set
    logic [CB-1:0]          r_cnt, n_cnt, b_cnt;
    logic signed [SW-1:0]   r_sum, n_sum, b_sum;
    logic [QW-1:0]          r_sqs, n_sqs, b_sqs;
    logic signed [SB-1:0]   r_min, n_min, b_min;
    logic signed [SB-1:0]   r_max, n_max, b_max;
    logic                   r_ovf, n_ovf;

    // report control
    logic                   r_busy;
    logic                   r_go;
    logic                   take;
    rss_pkg::t_rss_ctl      eng_ctl;
    logic                   eng_done;
    logic signed [SB-1:0]   eng_mean;
    logic [2*SB-1:0]        eng_var;
    logic [SB-1:0]          eng_dev;

    // result word register
    logic                            r_out_vld;
    logic [rss_pkg::OUT_DATA_W-1:0]  r_out_data;

    assign o_s_tready = ~r_busy;
    assign in_accept  = i_s_tvalid & ~r_busy;
    assign in_samp    = $signed(i_s_tdata[SB-1:0]);
    assign in_sq      = in_samp * in_samp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_p_samp <= in_samp;
            r_p_sq   <= $unsigned(in_sq);
            r_p_rst  <= i_s_tuser;
            r_p_rep  <= i_s_tlast;
        end
    end

    // restart clears first, then the sample folds in unless the count is full
    always_comb begin
        b_cnt = r_p_rst ? '0       : r_cnt;
        b_sum = r_p_rst ? '0       : r_sum;
        b_sqs = r_p_rst ? '0       : r_sqs;
        b_min = r_p_rst ? MOST_POS : r_min;
        b_max = r_p_rst ? MOST_NEG : r_max;
        n_ovf = r_p_rst ? 1'b0     : r_ovf;
        n_cnt = b_cnt;
        n_sum = b_sum;
        n_sqs = b_sqs;
        n_min = b_min;
        n_max = b_max;
        if (b_cnt == CNT_MAX) begin
            n_ovf = 1'b1;
        end else begin
            n_cnt = b_cnt + 1'b1;
            n_sum = b_sum + SW'(r_p_samp);
            n_sqs = b_sqs + QW'(r_p_sq);
            if (r_p_samp < b_min) n_min = r_p_samp;
            if (r_p_samp > b_max) n_max = r_p_samp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sum <= '0;
            r_sqs <= '0;
            r_min <= MOST_POS;
            r_max <= MOST_NEG;
            r_ovf <= 1'b0;
        end else if (r_p_vld) begin
            r_cnt <= n_cnt;
            r_sum <= n_sum;
            r_sqs <= n_sqs;
            r_min <= n_min;
            r_max <= n_max;
            r_ovf <= n_ovf;
        end
    end

    // busy from the report word until its result sits in the output register
    assign take          = eng_done & (~r_out_vld | i_m_tready);
    assign eng_ctl.start = r_go;
    assign eng_ctl.take  = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_go   <= 1'b0;
        end else begin
            r_go <= r_p_vld & r_p_rep;
            if (in_accept & i_s_tlast) begin
                r_busy <= 1'b1;
            end else if (take) begin
                r_busy <= 1'b0;
            end
        end
    end

    rss_engine #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (eng_ctl),
        .i_count (r_cnt),
        .i_sum   (r_sum),
        .i_sqsum (r_sqs),
        .o_done  (eng_done),
        .o_mean  (eng_mean),
        .o_var   (eng_var),
        .o_dev   (eng_dev)
    );

    // the set does not move while busy, so count, min, max and flag are current
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (take) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= {{rss_pkg::OUT_PAD_W{1'b0}},
                           r_ovf,
                           SMP_W'(r_max),
                           SMP_W'(r_min),
                           DEV_W'(eng_dev),
                           VAR_W'(eng_var),
                           SMP_W'(eng_mean),
                           CNT_W'(r_cnt)};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule
